### src/ale_pkg.sv
// Types, codes and command/response structs for the array list engine.
// Shared by ale_ctrl and the top level; no dependencies.
`default_nettype none

package ale_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 4;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT_AT    = 4'd0,
        FN_INSERT_FIRST = 4'd1,
        FN_INSERT_LAST  = 4'd2,
        FN_DELETE_AT    = 4'd3,
        FN_DELETE_KEY   = 4'd4,
        FN_REPLACE      = 4'd5,
        FN_GET          = 4'd6,
        FN_SEARCH       = 4'd7,
        FN_CLEAR        = 4'd8,
        FN_QUERY        = 4'd9
    } t_func;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_DN,
        S_PUT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_func                     func;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic                      found;
        t_status                   status;
        logic [LEN_W-1:0]          length;
        logic                      is_empty_flag;
        logic                      is_full_flag;
    } t_rsp;

endpackage

`default_nettype wire

### src/array_list_engine.sv
// Array list engine top level: entry RAM plus command sequencer.
// Depends on ale_pkg, ale_ram and ale_ctrl.
//
// Usage:
//   Commands enter on i_cmd (func, position, value) with i_cmd_valid /
//   o_cmd_ready; one response per command leaves on o_rsp with
//   o_rsp_valid / i_rsp_ready. The list is held packed from slot 0 in a
//   CAPACITY-deep RAM with one write and one registered read port.
//   Commands are handled one at a time: the next is taken once the last
//   has loaded its response. Query, clear, replace and rejected commands
//   go straight to the response; get reads its slot; insert at p moves
//   slots p to count - 1 up one, walking down one RAM read a cycle, then
//   writes p; delete at p, search and delete by key scan walks up, a
//   delete moving each later entry down one slot. The shift or scan walk
//   through the single RAM read port sets the rate.
//   Reset clears the count and the control state; the RAM is not cleared,
//   since only slots below the count are ever read.
//   A stalled receiver holds the response register; the engine takes the
//   next command but will not finish it until the register is free.
`default_nettype none

module array_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire ale_pkg::t_cmd i_cmd,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output ale_pkg::t_rsp      o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [ale_pkg::DATA_W-1:0]     ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [ale_pkg::DATA_W-1:0]     ram_rdata;

    ale_ram #(
        .WIDTH (ale_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ale_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### src/ale_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/ale_ctrl.sv
// Command sequencer: range checks, shift and scan walks over the entry RAM,
// list count and the response register. Depends on ale_pkg.
`default_nettype none

module ale_ctrl #(
    parameter int CAPACITY = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_ready,
    input  wire ale_pkg::t_cmd                 i_cmd,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_ready,
    output ale_pkg::t_rsp                      o_rsp,
    output logic                               o_ram_we,
    output logic [AW-1:0]                      o_ram_waddr,
    output logic [ale_pkg::DATA_W-1:0]         o_ram_wdata,
    output logic [AW-1:0]                      o_ram_raddr,
    input  wire logic [ale_pkg::DATA_W-1:0]    i_ram_rdata
);

    localparam int CMPW = (CW > ale_pkg::POS_W) ? CW : ale_pkg::POS_W;

    ale_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_pos, n_pos;
    logic [CW-1:0]                  r_ra, n_ra;
    logic [CW-1:0]                  r_wa, n_wa;
    logic                           r_inflt, n_inflt;
    logic                           r_seek, n_seek;
    logic                           r_bykey, n_bykey;
    logic                           r_del, n_del;
    logic                           r_ret, n_ret;
    logic [ale_pkg::DATA_W-1:0]     r_key, n_key;
    logic signed [ale_pkg::DATA_W-1:0] r_rd, n_rd;
    logic                           r_found, n_found;
    ale_pkg::t_status               r_st, n_st;
    logic                           r_rsp_valid, n_rsp_valid;
    ale_pkg::t_rsp                  r_rsp, n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ale_pkg::S_IDLE;
            r_count     <= '0;
            r_inflt     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_inflt     <= n_inflt;
            r_rsp_valid <= n_rsp_valid;
        end
        r_pos   <= n_pos;
        r_ra    <= n_ra;
        r_wa    <= n_wa;
        r_seek  <= n_seek;
        r_bykey <= n_bykey;
        r_del   <= n_del;
        r_ret   <= n_ret;
        r_key   <= n_key;
        r_rd    <= n_rd;
        r_found <= n_found;
        r_st    <= n_st;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        logic [CMPW-1:0] pos_ext;
        logic [CMPW-1:0] cnt_ext;
        logic [CMPW-1:0] ins_pos;
        logic [CW-1:0]   pos_cw;
        logic [CW-1:0]   wa_m1;
        logic [CW-1:0]   ra_m1;
        logic            full;
        logic            hit;
        logic            stop;
        logic            issue;

        pos_ext = CMPW'(i_cmd.position);
        cnt_ext = CMPW'(r_count);
        pos_cw  = pos_ext[CW-1:0];
        wa_m1   = r_wa - 1'b1;
        ra_m1   = r_ra - 1'b1;
        full    = (r_count == CW'(CAPACITY));
        hit     = 1'b0;
        stop    = 1'b0;
        issue   = 1'b0;

        priority case (i_cmd.func)
            ale_pkg::FN_INSERT_FIRST: ins_pos = '0;
            ale_pkg::FN_INSERT_LAST:  ins_pos = cnt_ext;
            default:                  ins_pos = pos_ext;
        endcase

        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ra        = r_ra;
        n_wa        = r_wa;
        n_inflt     = 1'b0;
        n_seek      = r_seek;
        n_bykey     = r_bykey;
        n_del       = r_del;
        n_ret       = r_ret;
        n_key       = r_key;
        n_rd        = r_rd;
        n_found     = r_found;
        n_st        = r_st;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;

        o_cmd_ready = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pos[AW-1:0];
        o_ram_wdata = r_key;
        o_ram_raddr = r_ra[AW-1:0];

        unique case (r_state)
            ale_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_rd    = '0;
                    n_found = 1'b0;
                    n_st    = ale_pkg::ST_OK;
                    n_key   = $unsigned(i_cmd.value);
                    n_state = ale_pkg::S_RESP;
                    unique case (i_cmd.func)
                        ale_pkg::FN_INSERT_AT,
                        ale_pkg::FN_INSERT_FIRST,
                        ale_pkg::FN_INSERT_LAST: begin
                            if (full) begin
                                n_st = ale_pkg::ST_FULL;
                            end else if (ins_pos > cnt_ext) begin
                                n_st = ale_pkg::ST_RANGE;
                            end else begin
                                n_pos   = ins_pos[CW-1:0];
                                n_ra    = r_count;
                                n_state = ale_pkg::S_SHIFT_DN;
                            end
                        end
                        ale_pkg::FN_DELETE_AT,
                        ale_pkg::FN_GET: begin
                            if (pos_ext < cnt_ext) begin
                                n_pos   = pos_cw;
                                n_ra    = pos_cw;
                                n_seek  = 1'b1;
                                n_bykey = 1'b0;
                                n_del   = (i_cmd.func == ale_pkg::FN_DELETE_AT);
                                n_ret   = 1'b1;
                                n_state = ale_pkg::S_SCAN;
                            end else begin
                                n_st = ale_pkg::ST_RANGE;
                            end
                        end
                        ale_pkg::FN_DELETE_KEY,
                        ale_pkg::FN_SEARCH: begin
                            n_ra    = '0;
                            n_seek  = 1'b1;
                            n_bykey = 1'b1;
                            n_del   = (i_cmd.func == ale_pkg::FN_DELETE_KEY);
                            n_ret   = (i_cmd.func == ale_pkg::FN_DELETE_KEY);
                            n_state = ale_pkg::S_SCAN;
                        end
                        ale_pkg::FN_REPLACE: begin
                            if (pos_ext < cnt_ext) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = pos_cw[AW-1:0];
                                o_ram_wdata = $unsigned(i_cmd.value);
                            end else begin
                                n_st = ale_pkg::ST_RANGE;
                            end
                        end
                        ale_pkg::FN_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ale_pkg::S_SCAN: begin
                // returned data belongs to address r_wa
                if (r_inflt && r_seek) begin
                    hit = r_bykey ? (i_ram_rdata == r_key) : (r_wa == r_pos);
                end
                stop = hit && !r_del;
                if (r_inflt && !r_seek) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = wa_m1[AW-1:0];
                    o_ram_wdata = i_ram_rdata;
                end
                if (hit) begin
                    n_seek = 1'b0;
                    n_rd   = r_ret ? $signed(i_ram_rdata) : '0;
                end
                issue       = !stop && (r_ra < r_count);
                o_ram_raddr = r_ra[AW-1:0];
                if (issue) begin
                    n_wa    = r_ra;
                    n_ra    = r_ra + 1'b1;
                    n_inflt = 1'b1;
                end else begin
                    n_state = ale_pkg::S_RESP;
                    if (r_seek && !hit) begin
                        n_st = ale_pkg::ST_ABSENT;
                    end else begin
                        n_found = r_bykey;
                        if (r_del) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
            end

            ale_pkg::S_SHIFT_DN: begin
                if (r_inflt) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_wa[AW-1:0];
                    o_ram_wdata = i_ram_rdata;
                end
                issue       = (r_ra > r_pos);
                o_ram_raddr = ra_m1[AW-1:0];
                if (issue) begin
                    n_wa    = r_ra;
                    n_ra    = ra_m1;
                    n_inflt = 1'b1;
                end else begin
                    n_state = ale_pkg::S_PUT;
                end
            end

            ale_pkg::S_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pos[AW-1:0];
                o_ram_wdata = r_key;
                n_count     = r_count + 1'b1;
                n_state     = ale_pkg::S_RESP;
            end

            ale_pkg::S_RESP: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid         = 1'b1;
                    n_rsp.read_value    = r_rd;
                    n_rsp.found         = r_found;
                    n_rsp.status        = r_st;
                    n_rsp.length        = cnt_ext[ale_pkg::LEN_W-1:0];
                    n_rsp.is_empty_flag = (r_count == '0);
                    n_rsp.is_full_flag  = full;
                    n_state             = ale_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ale_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

### dv/array_list_engine_checker.sv
`timescale 1ns / 1ps
// Command/response checker for array_list_engine: tracks the list contents,
// predicts each response and compares it field by field. Depends on ale_pkg.

module array_list_engine_checker #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  logic           i_cmd_ready,
    input  ale_pkg::t_cmd  i_cmd,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  ale_pkg::t_rsp  i_rsp,
    output int             o_errors,
    output int             o_pending
);

    logic signed [ale_pkg::DATA_W-1:0] slots [CAPACITY];
    int                                used;
    ale_pkg::t_rsp                     rsp_q [$];
    int                                err_cnt;

    function automatic logic signed [ale_pkg::DATA_W-1:0] pull_entry(int p);
        int k;
        pull_entry = slots[p];
        for (k = p; k + 1 < used; k++) slots[k] = slots[k + 1];
        used--;
    endfunction

    function automatic ale_pkg::t_rsp list_result(ale_pkg::t_cmd c);
        ale_pkg::t_rsp r;
        int            p;
        int            k;
        r = '0;
        r.status = ale_pkg::ST_OK;
        p = int'(c.position);
        case (c.func)
            ale_pkg::FN_INSERT_AT, ale_pkg::FN_INSERT_FIRST, ale_pkg::FN_INSERT_LAST: begin
                if (c.func == ale_pkg::FN_INSERT_FIRST) p = 0;
                if (c.func == ale_pkg::FN_INSERT_LAST) p = used;
                if (used >= CAPACITY) begin
                    r.status = ale_pkg::ST_FULL;
                end else if (p > used) begin
                    r.status = ale_pkg::ST_RANGE;
                end else begin
                    for (k = used; k > p; k--) slots[k] = slots[k - 1];
                    slots[p] = c.value;
                    used++;
                end
            end
            ale_pkg::FN_DELETE_AT: begin
                if (p < used) r.read_value = pull_entry(p);
                else r.status = ale_pkg::ST_RANGE;
            end
            ale_pkg::FN_DELETE_KEY, ale_pkg::FN_SEARCH: begin
                r.status = ale_pkg::ST_ABSENT;
                for (k = 0; k < used; k++) begin
                    if (slots[k] == c.value) begin
                        r.found = 1'b1;
                        r.status = ale_pkg::ST_OK;
                        if (c.func == ale_pkg::FN_DELETE_KEY) r.read_value = pull_entry(k);
                        break;
                    end
                end
            end
            ale_pkg::FN_REPLACE: begin
                if (p < used) slots[p] = c.value;
                else r.status = ale_pkg::ST_RANGE;
            end
            ale_pkg::FN_GET: begin
                if (p < used) r.read_value = slots[p];
                else r.status = ale_pkg::ST_RANGE;
            end
            ale_pkg::FN_CLEAR: begin
                used = 0;
            end
            default: begin
            end
        endcase
        r.length        = used[ale_pkg::LEN_W-1:0];
        r.is_empty_flag = (used == 0);
        r.is_full_flag  = (used == CAPACITY);
        return r;
    endfunction

    always @(posedge i_clk) begin
        ale_pkg::t_rsp want;
        if (!i_rst_n) begin
            rsp_q.delete();
            used = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_q.size() == 0) begin
                    $error("response item with no command outstanding");
                    err_cnt++;
                end else begin
                    want = rsp_q.pop_front();
                    if (i_rsp.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, i_rsp.read_value);
                        err_cnt++;
                    end
                    if (i_rsp.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_rsp.found);
                        err_cnt++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        err_cnt++;
                    end
                    if (i_rsp.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, i_rsp.length);
                        err_cnt++;
                    end
                    if (i_rsp.is_empty_flag !== want.is_empty_flag) begin
                        $error("is_empty_flag: expected %0d, got %0d",
                               want.is_empty_flag, i_rsp.is_empty_flag);
                        err_cnt++;
                    end
                    if (i_rsp.is_full_flag !== want.is_full_flag) begin
                        $error("is_full_flag: expected %0d, got %0d",
                               want.is_full_flag, i_rsp.is_full_flag);
                        err_cnt++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) rsp_q.push_back(list_result(i_cmd));
        end
        o_pending <= rsp_q.size();
        o_errors  <= err_cnt;
    end

endmodule

### dv/array_list_engine_test.sv
`timescale 1ns / 1ps
// Top of the array_list_engine test: clock, reset, command stimulus and verdict.
// Depends on ale_pkg, array_list_engine and array_list_engine_checker.

module array_list_engine_test;

    localparam int CAPACITY    = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 600;

    localparam logic signed [ale_pkg::DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [ale_pkg::DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_cmd_valid = 1'b0;
    logic           i_rsp_ready = 1'b0;
    ale_pkg::t_cmd  i_cmd       = '0;
    logic           o_cmd_ready;
    logic           o_rsp_valid;
    ale_pkg::t_rsp  o_rsp;

    int    errors;
    int    pending;
    int    snd_idle_pct = 8;
    int    rcv_idle_pct = 82;
    int    stall_cycles = 0;
    logic signed [ale_pkg::DATA_W-1:0] key_pool [8];

    always #4 i_clk = ~i_clk;

    array_list_engine #(.CAPACITY(CAPACITY)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    array_list_engine_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .i_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_rsp       (o_rsp),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd_valid && o_cmd_ready) || (o_rsp_valid && i_rsp_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_cmd(ale_pkg::t_cmd c);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_cmd_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_cmd_valid <= 1'b1;
        i_cmd       <= c;
        do @(posedge i_clk); while (!o_cmd_ready);
    endtask

    task automatic send(ale_pkg::t_func f, int p, logic signed [ale_pkg::DATA_W-1:0] v);
        ale_pkg::t_cmd c;
        c.func     = f;
        c.position = p[ale_pkg::POS_W-1:0];
        c.value    = v;
        send_cmd(c);
    endtask

    task automatic drain();
        i_cmd_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic ale_pkg::t_cmd next_cmd(bit grow);
        ale_pkg::t_cmd c;
        int unsigned   wt [10];
        int unsigned   total;
        int unsigned   pick;
        int            k;
        if (grow) wt = '{12, 8, 8, 6, 5, 8, 8, 8, 1, 6};
        else wt = '{4, 3, 3, 14, 14, 8, 8, 8, 1, 6};
        total = 0;
        for (k = 0; k < 10; k++) total += wt[k];
        pick = $urandom_range(total - 1);
        for (k = 0; k < 9; k++) begin
            if (pick < wt[k]) break;
            pick -= wt[k];
        end
        c.func = ale_pkg::t_func'(k[ale_pkg::FUNC_W-1:0]);
        if (c.func == ale_pkg::FN_QUERY && $urandom_range(1)) begin
            k = $urandom_range(15, 10);
            c.func = ale_pkg::t_func'(k[ale_pkg::FUNC_W-1:0]);
        end
        if ($urandom_range(9) == 0) c.position = $urandom_range(31, 17);
        else c.position = $urandom_range(16);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: c.value = key_pool[$urandom_range(7)];
            5: begin
                case ($urandom_range(3))
                    0: c.value = VMIN;
                    1: c.value = VMAX;
                    2: c.value = '0;
                    default: c.value = '1;
                endcase
            end
            default: c.value = $urandom;
        endcase
        return c;
    endfunction

    initial begin
        int ph;
        int n;
        foreach (key_pool[k]) key_pool[k] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(ale_pkg::FN_INSERT_AT, 0, VMIN);
        send(ale_pkg::FN_INSERT_FIRST, 0, VMAX);
        send(ale_pkg::FN_INSERT_LAST, 0, -1);
        send(ale_pkg::FN_INSERT_AT, 2, 0);
        send(ale_pkg::FN_INSERT_AT, 3, 32'sh5555_5555);
        repeat (11) send(ale_pkg::FN_INSERT_LAST, 0, $urandom);
        send(ale_pkg::FN_INSERT_FIRST, 0, 1);
        send(ale_pkg::FN_INSERT_AT, 31, 2);
        send(ale_pkg::FN_GET, 15, 0);
        send(ale_pkg::FN_REPLACE, 15, 32'shAAAA_AAAA);
        send(ale_pkg::FN_SEARCH, 0, -1);
        send(ale_pkg::FN_DELETE_KEY, 0, VMIN);
        send(ale_pkg::FN_DELETE_AT, 0, 0);
        send(ale_pkg::FN_DELETE_AT, 14, 0);
        send(ale_pkg::FN_REPLACE, 20, 3);
        send(ale_pkg::FN_INSERT_AT, 15, 4);
        send(ale_pkg::FN_CLEAR, 0, 0);
        send(ale_pkg::FN_SEARCH, 0, VMAX);
        send(ale_pkg::FN_DELETE_KEY, 0, 0);
        send(ale_pkg::FN_QUERY, 0, 0);
        send(ale_pkg::t_func'(4'hF), 31, -1);
        drain();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 8;
                    rcv_idle_pct = 82;
                end
                1: begin
                    snd_idle_pct = 82;
                    rcv_idle_pct = 8;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) send_cmd(next_cmd(((n / 40) % 2) == 0));
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
